[rtl/pmf_pkg.sv]
// ----------------------------------------------------------------------------
// pmf_pkg - shared types and constants of the pitch-modulated frequency block
// Holds field widths, the octave and index arithmetic constants, the exp2
// fraction table (built at elaboration), the controller states and the
// command group from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pmf_pkg;

   // Sample rate and fraction table size
   localparam int SAMPLE_RATE_HZ       = 48000;
   localparam int FRACTION_TABLE_DEPTH = 256;
   localparam int FRAC_IDX_W           = $clog2(FRACTION_TABLE_DEPTH);

   // Field widths
   localparam int HZ_W    = 23;   // unsigned Q15.8 Hz
   localparam int PITCH_W = 16;   // signed Q8.8 semitones
   localparam int SUM_W   = PITCH_W + 1;
   localparam int ENTRY_W = 31;   // unsigned Q1.30
   localparam int PROD_W  = HZ_W + ENTRY_W;

   // One octave is 12 semitones = 3072 in Q8.8, that is 1024 * 3
   localparam int SEMI_PER_OCT = 3072;
   localparam int OCT_LOW_W    = 10;
   localparam int REM_W        = 12;

   // Bias so that the biased pitch is never negative: ceil(2^16 / 3072)
   localparam int OCT_BIAS     = (65536 + SEMI_PER_OCT - 1) / SEMI_PER_OCT;
   localparam int BIAS_Q       = OCT_BIAS * SEMI_PER_OCT;
   localparam int BQ_W         = $clog2(BIAS_Q + 65535 + 1);
   localparam int OCT_W        = $clog2(2 * OCT_BIAS + 1);
   localparam int QHI_W        = BQ_W - OCT_LOW_W;

   // Divide by three: floor(x / 3) = (x * DIV3_RECIP) >> DIV3_SH for x < 2^15
   localparam int DIV3_SH      = 16;
   localparam int DIV3_RECIP   = (65536 + 2) / 3;
   localparam int DIV3_RECIP_W = 15;

   // Table index arithmetic: idx = floor(floor(r * DEPTH / 1024) / 3)
   localparam int RD_W     = REM_W + FRAC_IDX_W;
   localparam int XI_W     = RD_W - OCT_LOW_W;
   localparam int IDX_MW   = XI_W + DIV3_RECIP_W;

   // Right shift of the product is 30 - octave = SHIFT_BASE - biased octave
   localparam int SHIFT_BASE = 30 + OCT_BIAS;
   localparam int SHIFT_W    = $clog2(SHIFT_BASE + 1);

   // Output ceiling: Nyquist in Q15.8, at most the largest 23-bit value
   localparam longint LIMIT_RAW = longint'(SAMPLE_RATE_HZ) * 128;
   localparam longint OUT_MAX   = (longint'(1) << HZ_W) - 1;
   localparam logic [HZ_W-1:0] FREQ_LIMIT =
      HZ_W'((LIMIT_RAW > OUT_MAX) ? OUT_MAX : LIMIT_RAW);

   // Register reset values and indexes
   localparam logic [HZ_W-1:0]    BASE_HZ_RESET    = HZ_W'(112640);
   localparam logic [PITCH_W-1:0] BASE_PITCH_RESET = '0;
   localparam logic               CSR_BASE_HZ      = 1'b0;
   localparam logic               CSR_BASE_PITCH   = 1'b1;

   typedef logic [ENTRY_W-1:0] frac_tab_type [FRACTION_TABLE_DEPTH];

   // Unsigned 64-bit quotient by shift and subtract, used while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] part;
      quo  = '0;
      part = '0;
      for (int b = 63; b >= 0; b--) begin
         part = {part[63:0], num[b]};
         if (part >= {1'b0, den}) begin
            part   = part - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // 2^(i / DEPTH) in Q1.30, rounded, from a 60-bit fraction series
   function automatic frac_tab_type build_frac_tab();
      frac_tab_type tab;
      logic [63:0]  ln2;
      logic [63:0]  one;
      logic [63:0]  x;
      logic [63:0]  sum;
      logic [63:0]  term;
      logic [63:0]  ah;
      logic [63:0]  al;
      logic [63:0]  bh;
      logic [63:0]  bl;
      logic [63:0]  mid;
      logic [63:0]  prd;
      logic [63:0]  d;
      logic [63:0]  mask;
      logic [63:0]  ln2_q;
      logic [63:0]  ln2_r;
      int           k;
      ln2   = 64'h0B17217F7D1CF79B;
      one   = 64'h1000000000000000;
      mask  = 64'h000000003FFFFFFF;
      d     = 64'(FRACTION_TABLE_DEPTH);
      ln2_q = udiv64(ln2, d);
      ln2_r = ln2 - ln2_q * d;
      for (int i = 0; i < FRACTION_TABLE_DEPTH; i++) begin
         x    = ln2_q * 64'(i) + udiv64(ln2_r * 64'(i), d);
         sum  = one;
         term = one;
         k    = 1;
         while (k < 40 && term != 64'd0) begin
            ah   = term >> 30;
            al   = term & mask;
            bh   = x >> 30;
            bl   = x & mask;
            mid  = ah * bl + al * bh;
            prd  = ah * bh + (mid >> 30) + ((al * bl) >> 60);
            term = udiv64(prd, 64'(k));
            sum  = sum + term;
            k    = k + 1;
         end
         tab[i] = ENTRY_W'((sum + (64'd1 << 29)) >> 30);
      end
      return tab;
   endfunction

   localparam frac_tab_type FRAC_TAB = build_frac_tab();

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OCTAVE,
      ST_INDEX,
      ST_MULTIPLY,
      ST_SCALE
   } pmf_state_type;

   typedef struct packed {
      logic accept;    // item taken: update the accumulator
      logic oct_en;    // register biased pitch and octave
      logic idx_en;    // register fraction table entry
      logic mul_en;    // register product
      logic out_en;    // load the result register
   } pmf_cmd_type;

endpackage

`default_nettype wire

[rtl/pmf_ctrl.sv]
// ----------------------------------------------------------------------------
// pmf_ctrl - sequencer of the pitch-modulated frequency block
// Steps one item through octave, index, multiply and scale, and owns the
// valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pmf_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output pmf_pkg::pmf_cmd_type cmd
);

   pmf_pkg::pmf_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         pmf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               state_in = pmf_pkg::ST_OCTAVE;
            end
         end
         pmf_pkg::ST_OCTAVE: begin
            cmd.oct_en = 1'b1;
            state_in   = pmf_pkg::ST_INDEX;
         end
         pmf_pkg::ST_INDEX: begin
            cmd.idx_en = 1'b1;
            state_in   = pmf_pkg::ST_MULTIPLY;
         end
         pmf_pkg::ST_MULTIPLY: begin
            cmd.mul_en = 1'b1;
            state_in   = pmf_pkg::ST_SCALE;
         end
         pmf_pkg::ST_SCALE: begin
            // hold until the result register is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_en = 1'b1;
               state_in   = pmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pmf_pkg::ST_IDLE;
         end
      endcase

      if (cmd.out_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/pmf_dp.sv]
// ----------------------------------------------------------------------------
// pmf_dp - datapath of the pitch-modulated frequency block
// Configuration registers, saturating modulation accumulator, octave split,
// fraction table lookup, base frequency product, octave shift and ceiling.
// ----------------------------------------------------------------------------
`default_nettype none

module pmf_dp (
   input  wire                                clock,
   input  wire                                reset,
   input  wire  pmf_pkg::pmf_cmd_type         cmd,
   input  wire                                csr_we,
   input  wire                                csr_index,
   input  wire  [pmf_pkg::HZ_W-1:0]           csr_wdata,
   input  wire                                mode,
   input  wire  signed [pmf_pkg::PITCH_W-1:0] modulation_semitones,
   output logic [pmf_pkg::HZ_W-1:0]           frequency_hz,
   output logic                               clamped
);

   // configuration
   logic        [pmf_pkg::HZ_W-1:0]    base_hz_ff;
   logic signed [pmf_pkg::PITCH_W-1:0] base_pitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_hz_ff    <= pmf_pkg::BASE_HZ_RESET;
         base_pitch_ff <= pmf_pkg::BASE_PITCH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pmf_pkg::CSR_BASE_HZ:    base_hz_ff    <= csr_wdata;
            pmf_pkg::CSR_BASE_PITCH: base_pitch_ff <= csr_wdata[pmf_pkg::PITCH_W-1:0];
            default: ;
         endcase
      end
   end

   // saturating accumulator
   logic signed [pmf_pkg::PITCH_W-1:0] sum_ff, sum_in;
   logic signed [pmf_pkg::SUM_W-1:0]   acc_wide;
   logic signed [pmf_pkg::SUM_W-1:0]   acc_prev;

   always_comb begin
      acc_prev = mode ? '0 : {sum_ff[pmf_pkg::PITCH_W-1], sum_ff};
      acc_wide = acc_prev + {modulation_semitones[pmf_pkg::PITCH_W-1], modulation_semitones};
      if (acc_wide[pmf_pkg::SUM_W-1] != acc_wide[pmf_pkg::SUM_W-2]) begin
         sum_in = acc_wide[pmf_pkg::SUM_W-1] ? {1'b1, {(pmf_pkg::PITCH_W-1){1'b0}}}
                                             : {1'b0, {(pmf_pkg::PITCH_W-1){1'b1}}};
      end else begin
         sum_in = acc_wide[pmf_pkg::PITCH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (cmd.accept) begin
         sum_ff <= sum_in;
      end
   end

   // octave split on the biased pitch
   logic signed [pmf_pkg::SUM_W-1:0]          pitch;
   logic [pmf_pkg::BQ_W-1:0]                  bq;
   logic [pmf_pkg::QHI_W+pmf_pkg::DIV3_RECIP_W-1:0] oct_mul;
   logic [pmf_pkg::BQ_W-1:0]                  bq_ff;
   logic [pmf_pkg::OCT_W-1:0]                 oct_ff;

   always_comb begin
      pitch   = {base_pitch_ff[pmf_pkg::PITCH_W-1], base_pitch_ff}
              + {sum_ff[pmf_pkg::PITCH_W-1], sum_ff};
      bq      = pmf_pkg::BQ_W'(pitch) + pmf_pkg::BQ_W'(pmf_pkg::BIAS_Q);
      oct_mul = bq[pmf_pkg::BQ_W-1:pmf_pkg::OCT_LOW_W]
              * pmf_pkg::DIV3_RECIP_W'(pmf_pkg::DIV3_RECIP);
   end

   always_ff @(posedge clock) begin
      if (cmd.oct_en) begin
         bq_ff  <= bq;
         oct_ff <= pmf_pkg::OCT_W'(oct_mul >> pmf_pkg::DIV3_SH);
      end
   end

   // fraction table index and lookup
   logic [pmf_pkg::BQ_W-1:0]       rem_wide;
   logic [pmf_pkg::REM_W-1:0]      rem;
   logic [pmf_pkg::RD_W-1:0]       rd;
   logic [pmf_pkg::XI_W-1:0]       xi;
   logic [pmf_pkg::IDX_MW-1:0]     idx_mul;
   logic [pmf_pkg::IDX_MW-1:0]     idx_full;
   logic [pmf_pkg::FRAC_IDX_W-1:0] idx;
   logic [pmf_pkg::ENTRY_W-1:0]    entry_ff;

   always_comb begin
      rem_wide = bq_ff - pmf_pkg::BQ_W'(oct_ff) * pmf_pkg::BQ_W'(pmf_pkg::SEMI_PER_OCT);
      rem      = rem_wide[pmf_pkg::REM_W-1:0];
      rd       = {rem, {pmf_pkg::FRAC_IDX_W{1'b0}}};
      xi       = rd[pmf_pkg::RD_W-1:pmf_pkg::OCT_LOW_W];
      idx_mul  = xi * pmf_pkg::DIV3_RECIP_W'(pmf_pkg::DIV3_RECIP);
      idx_full = idx_mul >> pmf_pkg::DIV3_SH;
      if (idx_full >= pmf_pkg::IDX_MW'(pmf_pkg::FRACTION_TABLE_DEPTH)) begin
         idx = pmf_pkg::FRAC_IDX_W'(pmf_pkg::FRACTION_TABLE_DEPTH - 1);
      end else begin
         idx = idx_full[pmf_pkg::FRAC_IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_en) begin
         entry_ff <= pmf_pkg::FRAC_TAB[idx];
      end
   end

   // product
   logic [pmf_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= pmf_pkg::PROD_W'(base_hz_ff) * pmf_pkg::PROD_W'(entry_ff);
      end
   end

   // octave shift and ceiling
   logic [pmf_pkg::SHIFT_W-1:0] shift;
   logic [pmf_pkg::PROD_W-1:0]  scaled;
   logic                        over;
   logic [pmf_pkg::HZ_W-1:0]    freq_ff;
   logic                        clamped_ff;

   always_comb begin
      shift  = pmf_pkg::SHIFT_W'(pmf_pkg::SHIFT_BASE) - pmf_pkg::SHIFT_W'(oct_ff);
      scaled = prod_ff >> shift;
      over   = scaled > pmf_pkg::PROD_W'(pmf_pkg::FREQ_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (cmd.out_en) begin
         freq_ff    <= over ? pmf_pkg::FREQ_LIMIT : scaled[pmf_pkg::HZ_W-1:0];
         clamped_ff <= over;
      end
   end

   assign frequency_hz = freq_ff;
   assign clamped      = clamped_ff;

endmodule

`default_nettype wire

[rtl/pitch_modulated_frequency_top.sv]
// Each accepted item moves through registered steps: octave split, table lookup,
//   multiply, and shift and clamp; the sum moves at accept.
// One item runs at a time; the scale step waits until the result register can load.
// The result register frees the input side while a result waits downstream.
// Reset (synchronous, active high) clears the accumulator, sets base_hz to
//   440 Hz and base_pitch to 0, and empties the result register.
// ----------------------------------------------------------------------------
// pitch_modulated_frequency_top - pitch-modulated frequency generator
// Keeps a saturating Q8.8 semitone modulation sum and returns
// base_hz * 2^((base_pitch + sum) / 12) in Q15.8 Hz, limited to Nyquist.
// ----------------------------------------------------------------------------
`default_nettype none

module pitch_modulated_frequency_top (
   input  wire         clock,
   input  wire         reset,

   // configuration writes
   input  wire         csr_we,
   input  wire         csr_index,     // 0: base_hz, 1: base_pitch
   input  wire  [22:0] csr_wdata,

   // input items
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,     // [15:0] modulation_semitones
   input  wire  [0:0]  req_tuser,     // [0] mode

   // result items
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,     // [22:0] frequency_hz, [23] zero
   output logic [0:0]  rsp_tuser      // [0] clamped
);

   pmf_pkg::pmf_cmd_type           cmd;
   logic [pmf_pkg::HZ_W-1:0]       frequency_hz;
   logic                           clamped;

   // sequencer: walks each item through the datapath and owns rsp_tvalid
   pmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // datapath: configuration, accumulator and the frequency arithmetic
   pmf_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mode                 (req_tuser[0]),
      .modulation_semitones (req_tdata),
      .frequency_hz         (frequency_hz),
      .clamped              (clamped)
   );

   // pad the frequency to whole bytes
   assign rsp_tdata = {1'b0, frequency_hz};
   assign rsp_tuser = clamped;

endmodule

`default_nettype wire
